// ===== hdl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and codes for the speed limiter / cruise controller
// Holds the status, mode, event kind and action codes, and the link bytes.
// ----------------------------------------------------------------------------
package slc_pkg;

	// Limiter and cruise status
	typedef enum logic [1:0] {
		ST_OFF     = 2'd0,
		ST_ON      = 2'd1,
		ST_STANDBY = 2'd2
	} status_t;

	// Operating mode
	typedef enum logic [1:0] {
		MODE_MAIN   = 2'd0,
		MODE_CRUISE = 2'd1,
		MODE_LIMIT  = 2'd2,
		MODE_ALARM  = 2'd3
	} mode_t;

	// Event kind carried on the input tuser
	typedef enum logic [2:0] {
		KIND_LINK    = 3'd0,
		KIND_CRUISE  = 3'd1,
		KIND_LIMITER = 3'd2,
		KIND_STANDBY = 3'd3,
		KIND_INC     = 3'd4,
		KIND_DEC     = 3'd5
	} kind_t;

	// Reported action
	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_RESIST = 2'd1,
		ACT_ADJUST = 2'd2
	} action_t;

	// Link bytes with a fixed meaning; anything else is a speed
	localparam logic [7:0] BYTE_GAS     = 8'hFF;
	localparam logic [7:0] BYTE_BRAKE   = 8'hFE;
	localparam logic [7:0] BYTE_RELEASE = 8'hFD;

	// Result beat width: 34 bits of fields padded to whole bytes
	localparam int unsigned OUT_W = 40;

endpackage

// ===== hdl/speed_limiter_cruise_mode_controller.sv =====
// ----------------------------------------------------------------------------
// speed_limiter_cruise_mode_controller: limiter / cruise mode controller
// Takes button and link events, keeps mode, status and speeds, runs the
// control decision and reports one status beat per event.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents
// s_axis    in   tuser = kind[2:0]; tdata = payload[7:0]
// m_axis    out  tdata = mode, limiter_status, cruise_status, set_speed,
//                vehicle_speed, action, adjust_amount, alarm_on, buzzer_on
//
// One event per cycle sustained while m_axis is not stalled. An accepted
// event is held in the input register; the state update and the decision
// run combinationally from it, and the result loads into the output
// register on advance, from where the beat shows on m_axis.
// Reset clears the mode, statuses, speeds and flags to zero (main, off).
// A stalled output holds its beat; the input register still takes one more
// event, after that s_axis_tready drops until the output drains.

module speed_limiter_cruise_mode_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] payload
	input  logic [2:0]                      s_axis_tuser,  // [2:0] kind
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] mode, [3:2] limiter_status, [5:4] cruise_status,
	// [13:6] set_speed, [21:14] vehicle_speed, [23:22] action,
	// [31:24] adjust_amount, [32] alarm_on, [33] buzzer_on, [39:34] zero
	output logic [slc_pkg::OUT_W-1:0]       m_axis_tdata
);

	// Input register
	logic                 valid_s1;
	slc_pkg::kind_t       kind_s1;
	logic [7:0]           pay_s1;

	// Controller state
	slc_pkg::mode_t       mode_q;
	slc_pkg::status_t     lim_q;
	slc_pkg::status_t     cru_q;
	logic [7:0]           spd_q;
	logic [7:0]           meas_q;
	logic                 gas_q;
	logic                 alarm_q;

	// Output register
	logic                        out_valid_q;
	logic [slc_pkg::OUT_W-1:0]   out_data_q;

	// Next-state values
	slc_pkg::mode_t       mode_n;
	slc_pkg::status_t     lim_n;
	slc_pkg::status_t     cru_n;
	logic [7:0]           spd_n;
	logic [7:0]           meas_n;
	logic                 gas_n;
	logic                 alarm_n;
	logic                 go;
	logic                 brake;
	slc_pkg::action_t     act;
	logic [7:0]           amt;
	logic                 advance;

	// Move an event to the output when the output is free or drains
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Event handling followed by the control decision
	always_comb begin
		mode_n  = mode_q;
		lim_n   = lim_q;
		cru_n   = cru_q;
		spd_n   = spd_q;
		meas_n  = meas_q;
		gas_n   = gas_q;
		alarm_n = alarm_q;
		go      = 1'b0;
		brake   = 1'b0;
		act     = slc_pkg::ACT_NONE;
		amt     = 8'd0;

		unique case (kind_s1)
			slc_pkg::KIND_LINK: begin
				if (pay_s1 == slc_pkg::BYTE_GAS) begin
					gas_n = 1'b1;
					go    = 1'b1;
				end else if (pay_s1 == slc_pkg::BYTE_BRAKE) begin
					// brake counts only while cruise is on
					if (cru_q == slc_pkg::ST_ON) begin
						brake = 1'b1;
						go    = 1'b1;
					end
				end else if (pay_s1 == slc_pkg::BYTE_RELEASE) begin
					gas_n = 1'b0;
					go    = 1'b1;
				end else begin
					meas_n = pay_s1;
					go     = 1'b1;
				end
			end
			slc_pkg::KIND_CRUISE: begin
				if (cru_q == slc_pkg::ST_OFF) begin
					mode_n = slc_pkg::MODE_CRUISE;
					lim_n  = slc_pkg::ST_OFF;
					cru_n  = slc_pkg::ST_ON;
					spd_n  = 8'd0;
					go     = 1'b1;
				end else begin
					mode_n = slc_pkg::MODE_MAIN;
					cru_n  = slc_pkg::ST_OFF;
				end
			end
			slc_pkg::KIND_LIMITER: begin
				if (lim_q == slc_pkg::ST_OFF) begin
					mode_n = slc_pkg::MODE_LIMIT;
					cru_n  = slc_pkg::ST_OFF;
					lim_n  = slc_pkg::ST_ON;
					spd_n  = 8'd0;
					go     = 1'b1;
				end else begin
					mode_n = slc_pkg::MODE_MAIN;
					lim_n  = slc_pkg::ST_OFF;
				end
			end
			slc_pkg::KIND_STANDBY: begin
				if (lim_q == slc_pkg::ST_ON) begin
					lim_n  = slc_pkg::ST_STANDBY;
					mode_n = slc_pkg::MODE_MAIN;
				end else if (cru_q == slc_pkg::ST_ON) begin
					cru_n  = slc_pkg::ST_STANDBY;
					mode_n = slc_pkg::MODE_MAIN;
				end
			end
			slc_pkg::KIND_INC, slc_pkg::KIND_DEC: begin
				// resume from standby, else step the set speed
				if (lim_q == slc_pkg::ST_STANDBY) begin
					mode_n = slc_pkg::MODE_LIMIT;
					lim_n  = slc_pkg::ST_ON;
					go     = 1'b1;
				end else if (cru_q == slc_pkg::ST_STANDBY) begin
					mode_n = slc_pkg::MODE_CRUISE;
					cru_n  = slc_pkg::ST_ON;
					if (kind_s1 == slc_pkg::KIND_DEC) begin
						spd_n = meas_q;
					end
					go = 1'b1;
				end else if (mode_q != slc_pkg::MODE_MAIN) begin
					spd_n = (kind_s1 == slc_pkg::KIND_INC) ? spd_q + 8'd1 : spd_q - 8'd1;
					go    = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Control decision on the updated state
		if (go) begin
			if (lim_n == slc_pkg::ST_ON) begin
				if (spd_n == 8'd0) begin
					spd_n = meas_n;
					act   = slc_pkg::ACT_RESIST;
				end else if (meas_n == spd_n) begin
					act = slc_pkg::ACT_RESIST;
				end else if (meas_n > spd_n) begin
					mode_n  = slc_pkg::MODE_ALARM;
					alarm_n = 1'b1;
				end else if (mode_n == slc_pkg::MODE_ALARM) begin
					mode_n  = slc_pkg::MODE_MAIN;
					alarm_n = 1'b0;
				end
			end else if (cru_n == slc_pkg::ST_ON) begin
				if (spd_n == 8'd0) begin
					spd_n = meas_n;
					act   = slc_pkg::ACT_ADJUST;
				end else if (meas_n > spd_n) begin
					mode_n  = slc_pkg::MODE_ALARM;
					alarm_n = 1'b1;
				end else if (mode_n == slc_pkg::MODE_ALARM) begin
					mode_n  = slc_pkg::MODE_MAIN;
					alarm_n = 1'b0;
				end else begin
					act = slc_pkg::ACT_ADJUST;
					amt = spd_n - meas_n;
				end
				// brake drops cruise to standby
				if (brake) begin
					mode_n = slc_pkg::MODE_MAIN;
					cru_n  = slc_pkg::ST_STANDBY;
				end
			end
		end
	end

	// Input register: take a beat whenever ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= slc_pkg::kind_t'(s_axis_tuser);
			pay_s1  <= s_axis_tdata;
		end
	end

	// State update on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= slc_pkg::MODE_MAIN;
			lim_q   <= slc_pkg::ST_OFF;
			cru_q   <= slc_pkg::ST_OFF;
			spd_q   <= 8'd0;
			meas_q  <= 8'd0;
			gas_q   <= 1'b0;
			alarm_q <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_n;
			lim_q   <= lim_n;
			cru_q   <= cru_n;
			spd_q   <= spd_n;
			meas_q  <= meas_n;
			gas_q   <= gas_n;
			alarm_q <= alarm_n;
		end
	end

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {6'd0, alarm_n && !gas_n, alarm_n, amt, act, meas_n, spd_n,
				cru_n, lim_n, mode_n};
		end
	end

endmodule

// ===== hdl/slc_checker.sv =====
// ----------------------------------------------------------------------------
// slc_checker: port-level checks for the limiter / cruise controller
// Watches the result channel for held beats and consistent status fields.
// ----------------------------------------------------------------------------
module slc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [slc_pkg::OUT_W-1:0]  m_axis_tdata
);

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Buzzer only with the alarm, padding stays zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[33] && !m_axis_tdata[32])
			&& m_axis_tdata[39:34] == 6'd0)
		else $error("buzzer without alarm or nonzero padding");

	// Limiter and cruise are never active together
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:2] == slc_pkg::ST_OFF
			|| m_axis_tdata[5:4] == slc_pkg::ST_OFF)
		else $error("limiter and cruise both active");

	// Pedal resistance only with the limiter on
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23:22] == slc_pkg::ACT_RESIST
			|-> m_axis_tdata[3:2] == slc_pkg::ST_ON)
		else $error("pedal resistance without limiter on");

endmodule

bind speed_limiter_cruise_mode_controller slc_checker u_slc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== bench/slc_beat_checker.sv =====
// ----------------------------------------------------------------------------
// slc_beat_checker: status beat predictor and scoreboard
// Watches both stream channels of the speed limiter / cruise controller,
// predicts the status beat for each accepted event and compares every
// output beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module slc_beat_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // [7:0] payload
	input  logic [2:0]                s_axis_tuser,  // [2:0] kind
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [1:0] mode, [3:2] limiter_status, [5:4] cruise_status,
	// [13:6] set_speed, [21:14] vehicle_speed, [23:22] action,
	// [31:24] adjust_amount, [32] alarm_on, [33] buzzer_on, [39:34] zero
	input  logic [slc_pkg::OUT_W-1:0] m_axis_tdata,
	output int                        err_count,
	output int                        pending,
	output int                        beat_count,
	output int                        alarm_count,
	output int                        adjust_count,
	output int                        resist_count
);

	import slc_pkg::*;

	// Status beat layout, highest field first
	typedef struct packed {
		logic [5:0] pad;
		logic       buzzer_on;
		logic       alarm_on;
		logic [7:0] adjust_amount;
		action_t    action;
		logic [7:0] vehicle_speed;
		logic [7:0] set_speed;
		status_t    cruise_status;
		status_t    limiter_status;
		mode_t      mode;
	} status_beat_t;

	// Shadow of the controller state
	mode_t      cur_mode;
	status_t    lim_st;
	status_t    cru_st;
	logic [7:0] set_spd;
	logic [7:0] veh_spd;
	logic       gas_down;
	logic       alarm_set;

	status_beat_t predicted_beats[$];

	// Control decision: limiter takes priority over cruise
	function automatic void control_decision(input logic brake, output action_t act,
		output logic [7:0] amt);
		act = ACT_NONE;
		amt = 8'd0;
		if (lim_st == ST_ON) begin
			if (set_spd == 8'd0) begin
				set_spd = veh_spd;
				act = ACT_RESIST;
			end else if (veh_spd == set_spd) begin
				act = ACT_RESIST;
			end else if (veh_spd > set_spd) begin
				cur_mode = MODE_ALARM;
				alarm_set = 1'b1;
			end else if (cur_mode == MODE_ALARM) begin
				cur_mode = MODE_MAIN;
				alarm_set = 1'b0;
			end
		end else if (cru_st == ST_ON) begin
			if (set_spd == 8'd0) begin
				set_spd = veh_spd;
				act = ACT_ADJUST;
			end else if (veh_spd > set_spd) begin
				cur_mode = MODE_ALARM;
				alarm_set = 1'b1;
			end else if (cur_mode == MODE_ALARM) begin
				cur_mode = MODE_MAIN;
				alarm_set = 1'b0;
			end else begin
				act = ACT_ADJUST;
				amt = set_spd - veh_spd;
			end
			// A brake drops cruise to standby in its own step only
			if (brake) begin
				cur_mode = MODE_MAIN;
				cru_st = ST_STANDBY;
			end
		end
	endfunction

	// Increase / decrease: resume from standby, else nudge the set speed
	function automatic logic adjust_press(input logic up);
		if (lim_st == ST_STANDBY) begin
			cur_mode = MODE_LIMIT;
			lim_st = ST_ON;
			return 1'b1;
		end
		if (cru_st == ST_STANDBY) begin
			cur_mode = MODE_CRUISE;
			cru_st = ST_ON;
			if (!up)
				set_spd = veh_spd;
			return 1'b1;
		end
		if (cur_mode != MODE_MAIN) begin
			set_spd = up ? set_spd + 8'd1 : set_spd - 8'd1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Apply one event to the shadow state and build its status beat
	function automatic status_beat_t predict_event(input logic [2:0] kind,
		input logic [7:0] payload);
		logic         go;
		logic         brake;
		action_t      act;
		logic [7:0]   amt;
		status_beat_t r;
		go = 1'b0;
		brake = 1'b0;
		case (kind)
			KIND_LINK: begin
				if (payload == BYTE_GAS) begin
					gas_down = 1'b1;
					go = 1'b1;
				end else if (payload == BYTE_BRAKE) begin
					if (cru_st == ST_ON) begin
						brake = 1'b1;
						go = 1'b1;
					end
				end else if (payload == BYTE_RELEASE) begin
					gas_down = 1'b0;
					go = 1'b1;
				end else begin
					veh_spd = payload;
					go = 1'b1;
				end
			end
			KIND_CRUISE: begin
				if (cru_st == ST_OFF) begin
					cur_mode = MODE_CRUISE;
					lim_st = ST_OFF;
					cru_st = ST_ON;
					set_spd = 8'd0;
					go = 1'b1;
				end else begin
					cur_mode = MODE_MAIN;
					cru_st = ST_OFF;
				end
			end
			KIND_LIMITER: begin
				if (lim_st == ST_OFF) begin
					cur_mode = MODE_LIMIT;
					cru_st = ST_OFF;
					lim_st = ST_ON;
					set_spd = 8'd0;
					go = 1'b1;
				end else begin
					cur_mode = MODE_MAIN;
					lim_st = ST_OFF;
				end
			end
			KIND_STANDBY: begin
				if (lim_st == ST_ON) begin
					lim_st = ST_STANDBY;
					cur_mode = MODE_MAIN;
				end else if (cru_st == ST_ON) begin
					cru_st = ST_STANDBY;
					cur_mode = MODE_MAIN;
				end
			end
			KIND_INC: go = adjust_press(1'b1);
			KIND_DEC: go = adjust_press(1'b0);
			default: ;
		endcase
		act = ACT_NONE;
		amt = 8'd0;
		if (go)
			control_decision(brake, act, amt);
		r = '0;
		r.mode = cur_mode;
		r.limiter_status = lim_st;
		r.cruise_status = cru_st;
		r.set_speed = set_spd;
		r.vehicle_speed = veh_spd;
		r.action = act;
		r.adjust_amount = amt;
		r.alarm_on = alarm_set;
		r.buzzer_on = alarm_set & ~gas_down;
		return r;
	endfunction

	// Compare output beats first, then predict the newly accepted event
	always @(posedge clk or negedge arst_n) begin
		status_beat_t want;
		status_beat_t got;
		if (!arst_n) begin
			cur_mode = MODE_MAIN;
			lim_st = ST_OFF;
			cru_st = ST_OFF;
			set_spd = 8'd0;
			veh_spd = 8'd0;
			gas_down = 1'b0;
			alarm_set = 1'b0;
			predicted_beats.delete();
			err_count = 0;
			pending = 0;
			beat_count = 0;
			alarm_count = 0;
			adjust_count = 0;
			resist_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				beat_count++;
				if (predicted_beats.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: status beat %h arrived with no event pending",
							$realtime, got);
				end else begin
					want = predicted_beats.pop_front();
					if (got.mode !== want.mode ||
						got.limiter_status !== want.limiter_status ||
						got.cruise_status !== want.cruise_status ||
						got.set_speed !== want.set_speed ||
						got.vehicle_speed !== want.vehicle_speed ||
						got.action !== want.action ||
						got.adjust_amount !== want.adjust_amount ||
						got.alarm_on !== want.alarm_on ||
						got.buzzer_on !== want.buzzer_on) begin
						err_count++;
						if (err_count <= 10) begin
							$display("%0t: beat %0d mismatch", $realtime, beat_count);
							$display("  expected mode=%0d lim=%0d cru=%0d set=%0d veh=%0d act=%0d amt=%0d alarm=%b buzz=%b",
								want.mode, want.limiter_status, want.cruise_status,
								want.set_speed, want.vehicle_speed, want.action,
								want.adjust_amount, want.alarm_on, want.buzzer_on);
							$display("  actual   mode=%0d lim=%0d cru=%0d set=%0d veh=%0d act=%0d amt=%0d alarm=%b buzz=%b",
								got.mode, got.limiter_status, got.cruise_status,
								got.set_speed, got.vehicle_speed, got.action,
								got.adjust_amount, got.alarm_on, got.buzzer_on);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_event(s_axis_tuser, s_axis_tdata);
				if (want.alarm_on)
					alarm_count++;
				if (want.action == ACT_ADJUST)
					adjust_count++;
				if (want.action == ACT_RESIST)
					resist_count++;
				predicted_beats.push_back(want);
			end
			pending = predicted_beats.size();
		end
	end

endmodule

// ===== bench/speed_limiter_cruise_mode_controller_test.sv =====
// ----------------------------------------------------------------------------
// speed_limiter_cruise_mode_controller_test: top level of the controller bench
// Drives button and link events with random gaps and output stalls, lets the
// checker score every status beat, and reports the verdict.
// ----------------------------------------------------------------------------
module speed_limiter_cruise_mode_controller_test;

	import slc_pkg::*;

	// Kinds the controller does not decode
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	localparam int RANDOM_EVENTS = 1270;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = 8'd0;
	logic [2:0]           s_axis_tuser = 3'd0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;

	int err_count;
	int pending;
	int beat_count;
	int alarm_count;
	int adjust_count;
	int resist_count;

	int   sent = 0;
	int   directed = 0;
	int   idle_cycles = 0;
	logic calm = 1'b0;

	speed_limiter_cruise_mode_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	slc_beat_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.err_count     (err_count),
		.pending       (pending),
		.beat_count    (beat_count),
		.alarm_count   (alarm_count),
		.adjust_count  (adjust_count),
		.resist_count  (resist_count)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none or short, now and then long; none while calm
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Present one event beat and hold it until accepted
	task automatic send_event(input logic [2:0] kind, input logic [7:0] payload);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= payload;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Stall the output side at random
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = gap_len();
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("speed_limiter_cruise_mode_controller test failed");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int         r;
		int         base;
		logic [2:0] kind;
		logic [7:0] payload;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle controller: ignored brake, buttons with nothing to do, spare kinds
		send_event(KIND_LINK, 8'd0);
		send_event(KIND_LINK, BYTE_BRAKE);
		send_event(KIND_INC, 8'd0);
		send_event(KIND_DEC, 8'hFF);
		send_event(KIND_STANDBY, 8'd0);
		send_event(KIND_SPARE6, 8'hA5);
		send_event(KIND_SPARE7, 8'h5A);
		// Limiter: capture speed, overspeed alarm, recover, turn off with alarm held
		send_event(KIND_LINK, 8'd60);
		send_event(KIND_LIMITER, 8'd0);
		send_event(KIND_LINK, 8'd70);
		send_event(KIND_LINK, BYTE_GAS);
		send_event(KIND_LINK, 8'd50);
		send_event(KIND_LINK, 8'd90);
		send_event(KIND_LIMITER, 8'd0);
		send_event(KIND_LINK, BYTE_RELEASE);
		// Cruise: capture, nudge, overspeed, brake to standby, resume on decrease
		send_event(KIND_CRUISE, 8'd0);
		send_event(KIND_INC, 8'd0);
		send_event(KIND_DEC, 8'd0);
		send_event(KIND_DEC, 8'd0);
		send_event(KIND_LINK, BYTE_BRAKE);
		send_event(KIND_DEC, 8'd0);
		send_event(KIND_LINK, 8'd0);
		// Set speed wrap both ways with the largest adjust
		send_event(KIND_CRUISE, 8'd0);
		send_event(KIND_CRUISE, 8'd0);
		send_event(KIND_DEC, 8'd0);
		send_event(KIND_INC, 8'd0);
		// Limiter standby and resume on increase, top speed byte
		send_event(KIND_LIMITER, 8'd0);
		send_event(KIND_STANDBY, 8'd0);
		send_event(KIND_INC, 8'd0);
		send_event(KIND_LINK, 8'hFC);
		directed = sent;

		// Random sessions: speeds hover near a drifting base so that the set
		// speed comparisons go every way; some raw noise mixed in
		base = $urandom_range(20, 200);
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 5)
				base = $urandom_range(0, 255);
			else if (r < 25)
				base = (base + $urandom_range(0, 4) + 254) % 256;
			r = $urandom_range(0, 99);
			payload = 8'($urandom_range(0, 255));
			if (r < 38) begin
				kind = KIND_LINK;
				payload = 8'(base + $urandom_range(0, 6) - 3);
			end else if (r < 45) begin
				kind = KIND_LINK;
				payload = BYTE_GAS;
			end else if (r < 52) begin
				kind = KIND_LINK;
				payload = BYTE_RELEASE;
			end else if (r < 59) begin
				kind = KIND_LINK;
				payload = BYTE_BRAKE;
			end else if (r < 64) begin
				kind = KIND_CRUISE;
			end else if (r < 69) begin
				kind = KIND_LIMITER;
			end else if (r < 76) begin
				kind = KIND_STANDBY;
			end else if (r < 85) begin
				kind = KIND_INC;
			end else if (r < 94) begin
				kind = KIND_DEC;
			end else begin
				kind = 3'($urandom_range(0, 7));
			end
			send_event(kind, payload);
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then allow the pipeline to settle
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d events (%0d directed, %0d random), scored %0d status beats.",
			sent, directed, sent - directed, beat_count);
		$display("Beats with alarm set: %0d, speed adjusts: %0d, resistance requests: %0d.",
			alarm_count, adjust_count, resist_count);
		if (err_count == 0 && pending == 0)
			$display("speed_limiter_cruise_mode_controller test passed");
		else
			$display("speed_limiter_cruise_mode_controller test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/slc_pkg.sv
hdl/speed_limiter_cruise_mode_controller.sv
hdl/slc_checker.sv
bench/slc_beat_checker.sv
bench/speed_limiter_cruise_mode_controller_test.sv
